FILE: rtl/nearest_within_radius_top_k_select_defines.svh
// ----------------------------------------------------------------------------
// nearest-within-radius selector assertion macros
// shared concurrent assertion forms, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef NEAREST_WITHIN_RADIUS_TOP_K_SELECT_DEFINES_SVH
`define NEAREST_WITHIN_RADIUS_TOP_K_SELECT_DEFINES_SVH

`ifndef SYNTH
// condition holds in the same cycle as the trigger
`define NWR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nwr assertion failed");
// condition holds in the cycle after the trigger
`define NWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nwr assertion failed");
`else
`define NWR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define NWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/nwr_pkg.sv
// ----------------------------------------------------------------------------
// nwr_pkg
// shared types and codes of the nearest-within-radius selector
// ----------------------------------------------------------------------------
package nwr_pkg;

    // result field widths
    localparam int INDEX_BITS = 10;
    localparam int COUNT_BITS = 5;
    localparam int LIMIT_BITS = 5;

    // configuration register indexes
    localparam logic [1:0] REG_VOICE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_FILTER_FIRST = 2'd1;

    // per-cell tag carried along the row
    typedef struct packed {
        logic                  occupied;
        logic                  in_reach;
        logic [INDEX_BITS-1:0] index;
    } cell_tag_t;

    // row control, one for all cells
    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
    } cell_ctl_t;

endpackage

FILE: rtl/nwr_cell.sv
// ----------------------------------------------------------------------------
// nwr_cell
// one slot of the sorted row: keeps, clears, takes the new point, or takes its neighbor
// ----------------------------------------------------------------------------
module nwr_cell import nwr_pkg::*; #(
    parameter int DIST_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctl_t            ctl,
    input  logic [DIST_BITS-1:0] new_dist,
    input  cell_tag_t            new_tag,
    input  logic [DIST_BITS-1:0] prev_dist,
    input  cell_tag_t            prev_tag,
    input  logic                 prev_ahead,
    input  logic [DIST_BITS-1:0] next_dist,
    input  cell_tag_t            next_tag,
    output logic [DIST_BITS-1:0] cell_dist,
    output cell_tag_t            cell_tag,
    output logic                 ahead
);

    logic [DIST_BITS-1:0] dist_reg, dist_next;
    cell_tag_t            tag_reg, tag_next;

    // new point ranks before this cell; equal distance stays behind
    assign ahead = !tag_reg.occupied || (new_dist < dist_reg);

    // slot update
    always_comb begin
        dist_next = dist_reg;
        tag_next  = tag_reg;
        priority if (ctl.clear) begin
            tag_next.occupied = 1'b0;
        end else if (ctl.rotate) begin
            dist_next = next_dist;
            tag_next  = next_tag;
        end else if (ctl.insert && ahead) begin
            if (prev_ahead) begin
                dist_next = prev_dist;
                tag_next  = prev_tag;
            end else begin
                dist_next = new_dist;
                tag_next  = new_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
    end

    assign cell_dist = dist_reg;
    assign cell_tag  = tag_reg;

endmodule

FILE: rtl/nearest_within_radius_top_k_select.sv
// ----------------------------------------------------------------------------
// nearest_within_radius_top_k_select
// stable nearest-first selection of in-radius points, one frame at a time
// ----------------------------------------------------------------------------
// Points of a frame are taken one per cycle and sorted on the fly into a row
// of NUM_CELLS cells, each cycle inserting the new point where it ranks and
// pushing the tail cells one place down. After the point marked frame_end the
// input is held off: the row rotates once through its head cell to count
// the selected points, then rotates again handing out one index per
// selected cell, one cell a cycle up to the voice limit, then closes the
// frame, slowed only by m_ready. An empty frame gives one result after the
// count. Results leave through an output register, so the next frame may
// start while the last result waits to be taken.
// ----------------------------------------------------------------------------
`include "nearest_within_radius_top_k_select_defines.svh"

module nearest_within_radius_top_k_select import nwr_pkg::*; #(
    parameter int NUM_CELLS  = 16,
    parameter int MAX_POINTS = 1024,
    parameter int DIST_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [LIMIT_BITS-1:0] cfg_wdata,
    // point input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIST_BITS-1:0]  s_distance,
    input  logic [DIST_BITS-1:0]  s_reach,
    input  logic                  s_eligible,
    input  logic                  s_frame_end,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_BITS-1:0] m_voice_index,
    output logic [COUNT_BITS-1:0] m_selected_count,
    output logic                  m_empty_frame,
    output logic                  m_last_result,
    output logic                  m_too_many_points
);

    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int LW  = $clog2(NUM_CELLS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [LIMIT_BITS-1:0] cfg_limit_reg;
    logic                  cfg_ff_reg;
    logic [PCW-1:0]        point_cnt_reg, point_cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [LW-1:0]         lim_reg, lim_next;
    logic                  ff_frame_reg, ff_frame_next;
    logic [LW-1:0]         pos_reg, pos_next;
    logic [LW-1:0]         k_reg, k_next;
    logic [LW-1:0]         emit_reg, emit_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  load;
    logic [INDEX_BITS-1:0] out_index;
    logic                  out_empty;
    logic                  out_last;

    logic                  accept;
    logic                  at_cap;
    logic                  in_radius;
    logic                  out_free;
    logic                  head_sel;
    logic [LW-1:0]         limit_sat;
    cell_ctl_t             ctl;
    cell_tag_t             new_tag;

    logic [DIST_BITS-1:0]  dist_w [NUM_CELLS];
    cell_tag_t             tag_w  [NUM_CELLS];
    logic                  ahead_w [NUM_CELLS];
    logic [NUM_CELLS-1:0]  occ_w;

    // handshake and point classification
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign at_cap    = (point_cnt_reg >= PCW'(MAX_POINTS));
    assign in_radius = (s_distance <= s_reach);
    assign out_free  = !m_valid_reg || m_ready;
    assign head_sel  = tag_w[0].occupied && (tag_w[0].in_reach || ff_frame_reg);

    assign new_tag.occupied = 1'b1;
    assign new_tag.in_reach = in_radius;
    assign new_tag.index    = INDEX_BITS'(point_cnt_reg);

    // voice limit saturated at the row depth
    always_comb begin
        if (32'(cfg_limit_reg) > 32'(NUM_CELLS)) begin
            limit_sat = LW'(NUM_CELLS);
        end else begin
            limit_sat = LW'(cfg_limit_reg);
        end
    end

    // row of sorting cells
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NXT  = (i + 1) % NUM_CELLS;
        nwr_cell #(
            .DIST_BITS (DIST_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .new_dist   (s_distance),
            .new_tag    (new_tag),
            .prev_dist  (dist_w[PREV]),
            .prev_tag   (tag_w[PREV]),
            .prev_ahead ((i == 0) ? 1'b0 : ahead_w[PREV]),
            .next_dist  (dist_w[NXT]),
            .next_tag   (tag_w[NXT]),
            .cell_dist  (dist_w[i]),
            .cell_tag   (tag_w[i]),
            .ahead      (ahead_w[i])
        );
        assign occ_w[i] = tag_w[i].occupied;
    end

    // frame sequencer
    always_comb begin
        state_next     = state_reg;
        point_cnt_next = point_cnt_reg;
        ovf_next       = ovf_reg;
        lim_next       = lim_reg;
        ff_frame_next  = ff_frame_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        emit_next      = emit_reg;
        ctl            = '0;
        load           = 1'b0;
        out_index      = tag_w[0].index;
        out_empty      = 1'b0;
        out_last       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (at_cap) begin
                        ovf_next = 1'b1;
                    end else begin
                        ctl.insert     = s_eligible && (!cfg_ff_reg || in_radius);
                        point_cnt_next = PCW'(point_cnt_reg + 1'b1);
                    end
                    if (s_frame_end) begin
                        state_next    = ST_COUNT;
                        lim_next      = limit_sat;
                        ff_frame_next = cfg_ff_reg;
                        pos_next      = '0;
                        k_next        = '0;
                    end
                end
            end
            ST_COUNT: begin
                // one full rotation, counting selected cells inside the limit
                ctl.rotate = 1'b1;
                pos_next   = LW'(pos_reg + 1'b1);
                if (head_sel && (pos_reg < lim_reg)) begin
                    k_next = LW'(k_reg + 1'b1);
                end
                if (pos_reg == LW'(NUM_CELLS - 1)) begin
                    pos_next   = '0;
                    emit_next  = '0;
                    state_next = (k_next == '0) ? ST_EMPTY : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if ((pos_reg == lim_reg) || (emit_reg == k_reg)) begin
                    ctl.clear      = 1'b1;
                    point_cnt_next = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end else if (head_sel) begin
                    if (out_free) begin
                        load       = 1'b1;
                        out_last   = (LW'(emit_reg + 1'b1) == k_reg);
                        ctl.rotate = 1'b1;
                        pos_next   = LW'(pos_reg + 1'b1);
                        emit_next  = LW'(emit_reg + 1'b1);
                    end
                end else begin
                    ctl.rotate = 1'b1;
                    pos_next   = LW'(pos_reg + 1'b1);
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    load           = 1'b1;
                    out_index      = '0;
                    out_empty      = 1'b1;
                    out_last       = 1'b1;
                    ctl.clear      = 1'b1;
                    point_cnt_next = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            point_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            lim_reg       <= '0;
            ff_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            k_reg         <= '0;
            emit_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            point_cnt_reg <= point_cnt_next;
            ovf_reg       <= ovf_next;
            lim_reg       <= lim_next;
            ff_frame_reg  <= ff_frame_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            emit_reg      <= emit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_limit_reg <= LIMIT_BITS'(16);
            cfg_ff_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VOICE_LIMIT:  cfg_limit_reg <= cfg_wdata;
                REG_FILTER_FIRST: cfg_ff_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_voice_index     <= out_index;
            m_selected_count  <= out_empty ? '0 : COUNT_BITS'(k_reg);
            m_empty_frame     <= out_empty;
            m_last_result     <= out_last;
            m_too_many_points <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    `NWR_ASSERT_NOW(a_occ_prefix, aclk, aresetn, state_reg == ST_IDLE, (occ_w & (occ_w + 1'b1)) == '0)
    `NWR_ASSERT_NOW(a_emit_bound, aclk, aresetn, state_reg == ST_EMIT, emit_reg <= k_reg)
    `NWR_ASSERT_NEXT(a_cnt_cap, aclk, aresetn, accept, point_cnt_reg <= PCW'(MAX_POINTS))

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nearest-within-radius top-k selector
// ----------------------------------------------------------------------------
// Frames of points go in through a bursty valid/ready driver. The bench keeps
// its own sorted voice store, so every accepted point updates the predicted
// selection and every frame end queues the indices due out. A monitor checks
// each result item against the oldest due entry, field by field. Mode
// registers are changed only between phases, once the selector has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import nwr_pkg::*;

    localparam int VOICES      = 16;
    localparam int POINT_LIMIT = 1024;
    localparam int DIST_W      = 32;
    localparam int DRAIN_WAIT  = 48;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] reach;
        logic              eligible;
        logic              frame_end;
    } point_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] voice_index;
        logic [COUNT_BITS-1:0] count;
        logic                  empty;
        logic                  last;
        logic                  overflow;
    } voice_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = REG_VOICE_LIMIT;
    logic [LIMIT_BITS-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DIST_W-1:0]     s_distance = '0;
    logic [DIST_W-1:0]     s_reach = '0;
    logic                  s_eligible = 1'b0;
    logic                  s_frame_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [INDEX_BITS-1:0] m_voice_index;
    logic [COUNT_BITS-1:0] m_selected_count;
    logic                  m_empty_frame;
    logic                  m_last_result;
    logic                  m_too_many_points;

    nearest_within_radius_top_k_select #(
        .NUM_CELLS  (VOICES),
        .MAX_POINTS (POINT_LIMIT),
        .DIST_BITS  (DIST_W)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_distance        (s_distance),
        .s_reach           (s_reach),
        .s_eligible        (s_eligible),
        .s_frame_end       (s_frame_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_voice_index     (m_voice_index),
        .m_selected_count  (m_selected_count),
        .m_empty_frame     (m_empty_frame),
        .m_last_result     (m_last_result),
        .m_too_many_points (m_too_many_points)
    );

    // point items waiting to be sent, selections waiting to come out
    point_t point_queue[$];
    voice_t voices_due[$];
    point_t drv_point;
    voice_t want_voice;

    // bench copy of the selector state and mode
    logic [DIST_W-1:0]     rank_dist  [VOICES];
    logic [INDEX_BITS-1:0] rank_index [VOICES];
    logic                  rank_inside[VOICES];
    logic                  rank_used  [VOICES];
    logic [10:0]           points_seen = '0;
    logic                  frame_overflow = 1'b0;
    logic [LIMIT_BITS-1:0] limit_setting = 5'd16;
    logic                  filter_setting = 1'b0;

    // traffic shaping knobs
    int gap_max = 0;
    int stall_pct = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int error_count = 0;
    logic item_taken = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // predicted store update for one accepted point
    task automatic rank_point(input point_t pt);
        logic                  inside_now;
        int                    slot;
        int                    lim;
        int                    picked;
        logic [INDEX_BITS-1:0] pick_index[VOICES];
        voice_t                res;
        inside_now = pt.distance <= pt.reach;
        if (points_seen >= POINT_LIMIT) begin
            frame_overflow = 1'b1;
        end else begin
            if (pt.eligible && (!filter_setting || inside_now)) begin
                // stable insert: equal distances stay behind earlier points
                slot = 0;
                while (slot < VOICES && rank_used[slot] && rank_dist[slot] <= pt.distance)
                    slot++;
                if (slot < VOICES) begin
                    for (int i = VOICES - 1; i > slot; i--) begin
                        rank_dist[i]   = rank_dist[i-1];
                        rank_index[i]  = rank_index[i-1];
                        rank_inside[i] = rank_inside[i-1];
                        rank_used[i]   = rank_used[i-1];
                    end
                    rank_dist[slot]   = pt.distance;
                    rank_index[slot]  = points_seen[INDEX_BITS-1:0];
                    rank_inside[slot] = inside_now;
                    rank_used[slot]   = 1'b1;
                end
            end
            points_seen++;
        end
        if (!pt.frame_end)
            return;
        // pick up to the voice limit, radius applied here in rank-first mode
        lim = (limit_setting > VOICES) ? VOICES : limit_setting;
        picked = 0;
        for (int i = 0; i < lim; i++) begin
            if (!rank_used[i])
                break;
            if (rank_inside[i] || filter_setting) begin
                pick_index[picked] = rank_index[i];
                picked++;
            end
        end
        if (picked == 0) begin
            res = '{voice_index: '0, count: '0, empty: 1'b1, last: 1'b1,
                    overflow: frame_overflow};
            voices_due = {voices_due, res};
        end
        for (int i = 0; i < picked; i++) begin
            res = '{voice_index: pick_index[i], count: COUNT_BITS'(picked), empty: 1'b0,
                    last: (i == picked - 1), overflow: frame_overflow};
            voices_due = {voices_due, res};
        end
        // new frame
        for (int i = 0; i < VOICES; i++) begin
            rank_dist[i]   = '0;
            rank_index[i]  = '0;
            rank_inside[i] = 1'b0;
            rank_used[i]   = 1'b0;
        end
        points_seen = '0;
        frame_overflow = 1'b0;
    endtask

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // accepted point items feed the predictor
    always @(posedge aclk) begin
        item_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            rank_point('{distance: s_distance, reach: s_reach, eligible: s_eligible,
                         frame_end: s_frame_end});
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (voices_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item, expected none, actual index %0d",
                         $time, m_voice_index);
            end else begin
                want_voice = voices_due.pop_front();
                compare_field("voice_index", want_voice.voice_index, m_voice_index);
                compare_field("selected_count", want_voice.count, m_selected_count);
                compare_field("empty_frame", want_voice.empty, m_empty_frame);
                compare_field("last_result", want_voice.last, m_last_result);
                compare_field("too_many_points", want_voice.overflow, m_too_many_points);
            end
        end
    end

    // point driver: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !item_taken) begin
            // hold the offered item
        end else if (gap_left != 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (point_queue.size() != 0) begin
            drv_point = point_queue.pop_front();
            s_valid     <= 1'b1;
            s_distance  <= drv_point.distance;
            s_reach     <= drv_point.reach;
            s_eligible  <= drv_point.eligible;
            s_frame_end <= drv_point.frame_end;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result receiver: random stalls, long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void push_point(input logic [DIST_W-1:0] d, input logic [DIST_W-1:0] r,
                                       input logic elig, input logic fend);
        point_t pt;
        pt = '{distance: d, reach: r, eligible: elig, frame_end: fend};
        point_queue = {point_queue, pt};
    endfunction

    // one frame of random content, distance spread picked per frame
    function automatic int queue_frame(input int len);
        int                spread;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] r;
        spread = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
            case (spread)
                0: begin
                    d = $urandom_range(0, 7);
                    r = $urandom_range(0, 7);
                end
                1: begin
                    d = $urandom;
                    r = $urandom;
                end
                default: begin
                    d = $urandom_range(0, 4000);
                    r = $urandom_range(0, 4000);
                end
            endcase
            push_point(d, r, $urandom_range(0, 4) != 0, i == len - 1);
        end
        return len;
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (point_queue.size() != 0 || s_valid || voices_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // both mode registers, written back to back while idle
    task automatic write_modes(input logic [LIMIT_BITS-1:0] lim, input logic ff);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VOICE_LIMIT;
        cfg_wdata <= lim;
        @(negedge aclk);
        cfg_index <= REG_FILTER_FIRST;
        cfg_wdata <= {4'd0, ff};
        @(negedge aclk);
        cfg_we <= 1'b0;
        limit_setting = lim;
        filter_setting = ff;
    endtask

    // phase settings: limit, filter mode
    logic [LIMIT_BITS-1:0] phase_limit[8] = '{5'd0, 5'd0, 5'd1, 5'd31, 5'd16, 5'd7, 5'd3, 5'd16};
    logic                  phase_ff[8]    = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    initial begin
        int queued;
        for (int i = 0; i < VOICES; i++) begin
            rank_dist[i]   = '0;
            rank_index[i]  = '0;
            rank_inside[i] = 1'b0;
            rank_used[i]   = 1'b0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames under reset modes
        // distance equal to radius counts as inside
        push_point(32'd0, 32'd0, 1'b1, 1'b1);
        // extremes, an ineligible point and a tie
        push_point(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 1'b0);
        push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_point(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_point(32'd100, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_point(32'd100, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // nothing eligible, then only an out-of-radius point: both empty
        push_point(32'd5, 32'd9, 1'b0, 1'b1);
        push_point(32'd10, 32'd9, 1'b1, 1'b1);
        // store full: fill, push the tail out, then a point ranking behind all
        for (int i = 0; i < VOICES; i++)
            push_point(32'd100 + i, 32'd1000, 1'b1, 1'b0);
        push_point(32'd50, 32'd1000, 1'b1, 1'b0);
        push_point(32'd900, 32'd1000, 1'b1, 1'b1);
        gap_max = 3;
        stall_pct = 30;
        wait_drained();

        // random phases across mode settings
        for (int p = 0; p < 8; p++) begin
            write_modes(phase_limit[p], phase_ff[p]);
            gap_max = (p == 2) ? 0 : $urandom_range(0, 8);
            stall_pct = (p == 2) ? 0 : $urandom_range(0, 80);
            if (p == 4) begin
                // receiver holds off while points keep coming
                gap_max = 0;
                stall_pct = 0;
                queued = 0;
                while (queued < 40)
                    queued += queue_frame($urandom_range(3, 20));
                hold_req++;
            end else begin
                queued = 0;
                while (queued < 20)
                    queued += queue_frame($urandom_range(1, 22));
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/nwr_pkg.sv
rtl/nwr_cell.sv
rtl/nearest_within_radius_top_k_select.sv
sim/tb_top.sv
